@@ rtl/tpe_pkg.sv @@
package tpe_pkg;

  localparam int COORD_BITS = 12;
  localparam int CNT_W      = $clog2(COORD_BITS);
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  localparam int CFG_W    = 12;
  localparam int THR_W    = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_PANEL_W  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_H  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RES_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RES_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DRAG_THR = 3'd4;

  localparam logic [CFG_W-1:0] PANEL_W_RST  = 12'd720;
  localparam logic [CFG_W-1:0] PANEL_H_RST  = 12'd1280;
  localparam logic [CFG_W-1:0] RES_X_RST    = 12'd720;
  localparam logic [CFG_W-1:0] RES_Y_RST    = 12'd1280;
  localparam logic [THR_W-1:0] DRAG_THR_RST = 8'd10;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_UP   = 2'd1,
    EV_DRAG = 2'd2
  } ev_kind_e;

  typedef struct packed {
    logic                  touch_present;
    logic [COORD_BITS-1:0] raw_x;
    logic [COORD_BITS-1:0] raw_y;
  } in_item_t;

  typedef struct packed {
    ev_kind_e              event_kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
  } out_item_t;

endpackage

@@ rtl/touch_pen_event_generator.sv @@
// a touch item runs a bit-serial multiply, then a restoring divide, for x and y side by side,
// then a decision step; a no-touch item goes straight to the decision step
// a new item is taken only once the last one has been decided
// a waiting event holds off the next decision only
// reset: released, last position 0, registers back to 720/1280/720/1280/10, no event pending
module touch_pen_event_generator import tpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCALE  = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [CFG_W-1:0] panel_w_q, panel_h_q, res_x_q, res_y_q;
  logic [THR_W-1:0] drag_thr_q;

  logic [1:0]            state_q, state_d;
  logic                  present_q, present_d;
  logic                  touched_q, touched_d;
  logic [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic                  in_accept, start, cfg_wr, slot_free;
  logic                  x_done, y_done;
  logic [COORD_BITS-1:0] x_coord, y_coord, dx, dy, thr_ext;
  logic                  moved;
  logic [REG_IDX_W-1:0]  reg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_w_q  <= PANEL_W_RST;
      panel_h_q  <= PANEL_H_RST;
      res_x_q    <= RES_X_RST;
      res_y_q    <= RES_Y_RST;
      drag_thr_q <= DRAG_THR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PANEL_W:  panel_w_q  <= pwdata[CFG_W-1:0];
        REG_PANEL_H:  panel_h_q  <= pwdata[CFG_W-1:0];
        REG_RES_X:    res_x_q    <= pwdata[CFG_W-1:0];
        REG_RES_Y:    res_y_q    <= pwdata[CFG_W-1:0];
        REG_DRAG_THR: drag_thr_q <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PANEL_W:  prdata = {{(DATA_W-CFG_W){1'b0}}, panel_w_q};
      REG_PANEL_H:  prdata = {{(DATA_W-CFG_W){1'b0}}, panel_h_q};
      REG_RES_X:    prdata = {{(DATA_W-CFG_W){1'b0}}, res_x_q};
      REG_RES_Y:    prdata = {{(DATA_W-CFG_W){1'b0}}, res_y_q};
      REG_DRAG_THR: prdata = {{(DATA_W-THR_W){1'b0}}, drag_thr_q};
      default:      prdata = '0;
    endcase
  end

  // item flow
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign start      = in_accept && in_item_i.touch_present;

  tpe_scaler u_scale_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .raw_i   (in_item_i.raw_x),
    .size_i  (panel_w_q),
    .res_i   (res_x_q),
    .done_o  (x_done),
    .coord_o (x_coord)
  );

  tpe_scaler u_scale_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .raw_i   (in_item_i.raw_y),
    .size_i  (panel_h_q),
    .res_i   (res_y_q),
    .done_o  (y_done),
    .coord_o (y_coord)
  );

  assign dx      = (x_coord > last_x_q) ? (x_coord - last_x_q) : (last_x_q - x_coord);
  assign dy      = (y_coord > last_y_q) ? (y_coord - last_y_q) : (last_y_q - y_coord);
  assign thr_ext = {{(COORD_BITS-THR_W){1'b0}}, drag_thr_q};
  assign moved   = (dx > thr_ext) || (dy > thr_ext);

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    touched_d   = touched_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          present_d = in_item_i.touch_present;
          state_d   = in_item_i.touch_present ? S_SCALE : S_DECIDE;
        end
      end
      S_SCALE: begin
        if (x_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // wait until the output register can take the event
        if (slot_free) begin
          state_d = S_IDLE;
          if (!present_q) begin
            if (touched_q) begin
              touched_d   = 1'b0;
              out_valid_d = 1'b1;
              out_item_d  = '{event_kind: EV_UP, pos_x: last_x_q, pos_y: last_y_q};
            end
          end else if (!touched_q || moved) begin
            touched_d   = 1'b1;
            last_x_d    = x_coord;
            last_y_d    = y_coord;
            out_valid_d = 1'b1;
            out_item_d  = '{event_kind: (touched_q ? EV_DRAG : EV_DOWN),
                            pos_x: x_coord, pos_y: y_coord};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= 1'b0;
      touched_q   <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      touched_q   <= touched_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // both axes run the same fixed schedule
  assert property (@(posedge clk_i) disable iff (!rst_ni) x_done == y_done)
    else $error("x and y scalers out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> in_stall_o)
    else $error("item accepted while previous one still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_o) |-> $past(state_q == S_DECIDE))
    else $error("event raised outside the decision step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ($rose(out_valid_o) && out_item_o.event_kind == EV_UP) |-> !touched_q)
    else $error("pen-up issued while still touched");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ($rose(out_valid_o) && out_item_o.event_kind != EV_UP) |-> touched_q)
    else $error("pen-down or drag issued while released");

endmodule

@@ rtl/tpe_scaler.sv @@
module tpe_scaler import tpe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] raw_i,
  input  logic [COORD_BITS-1:0] size_i,
  input  logic [COORD_BITS-1:0] res_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] coord_o
);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_DIV  = 2'd2;
  localparam logic [1:0] SC_DONE = 2'd3;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COORD_BITS - 1);

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [COORD_BITS-1:0]   raw_q, raw_d;
  logic [COORD_BITS-1:0]   size_q, size_d;
  logic [2*COORD_BITS-1:0] pr_q, pr_d;
  logic                    sat_q, sat_d;

  logic [COORD_BITS:0]     trial;
  logic [COORD_BITS+1:0]   diff;
  logic                    ge;
  logic [COORD_BITS-1:0]   rem_nxt;

  // restoring division step: partial remainder stays below the divisor
  assign trial   = {pr_q[2*COORD_BITS-1:COORD_BITS], pr_q[COORD_BITS-1]};
  assign diff    = {1'b0, trial} - {2'b00, res_i};
  assign ge      = ~diff[COORD_BITS+1];
  assign rem_nxt = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    raw_d   = raw_q;
    size_d  = size_q;
    pr_d    = pr_q;
    sat_d   = sat_q;
    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          raw_d   = raw_i;
          size_d  = size_i;
          pr_d    = '0;
          cnt_d   = '0;
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        // shift-add, one multiplier bit per cycle, msb first
        pr_d   = {pr_q[2*COORD_BITS-2:0], 1'b0} +
                 (size_q[COORD_BITS-1] ? {{COORD_BITS{1'b0}}, raw_q} : '0);
        size_d = {size_q[COORD_BITS-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          cnt_d   = '0;
          state_d = SC_DIV;
        end
      end
      SC_DIV: begin
        // quotient overflows (or divisor is zero) when the high half reaches res
        if (cnt_q == '0) begin
          sat_d = (pr_q[2*COORD_BITS-1:COORD_BITS] >= res_i);
        end
        pr_d  = {rem_nxt, pr_q[COORD_BITS-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          cnt_d   = '0;
          state_d = SC_DONE;
        end
      end
      SC_DONE: begin
        state_d = SC_IDLE;
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q  <= raw_d;
    size_q <= size_d;
    pr_q   <= pr_d;
    sat_q  <= sat_d;
  end

  assign done_o  = (state_q == SC_DONE);
  assign coord_o = sat_q ? COORD_MAX : pr_q[COORD_BITS-1:0];

endmodule

@@ tb/sv/tb_touch_pen_event_generator.sv @@
`timescale 1ns / 1ps

module tb_touch_pen_event_generator;
  import tpe_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 8;
  // settle beyond the time a touch item needs to pass scaling and decision
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PRINT_CAP     = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_POLLS   = 230;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // register shadow and pen state of the predictor
  logic [CFG_W-1:0]      cfg_panel_w  = PANEL_W_RST;
  logic [CFG_W-1:0]      cfg_panel_h  = PANEL_H_RST;
  logic [CFG_W-1:0]      cfg_res_x    = RES_X_RST;
  logic [CFG_W-1:0]      cfg_res_y    = RES_Y_RST;
  logic [THR_W-1:0]      cfg_drag_thr = DRAG_THR_RST;
  logic                  pen_touched  = 1'b0;
  logic [COORD_BITS-1:0] last_px      = '0;
  logic [COORD_BITS-1:0] last_py      = '0;

  out_item_t pending_events[$];

  int error_count    = 0;
  int polls_sent     = 0;
  int downs_seen     = 0;
  int ups_seen       = 0;
  int drags_seen     = 0;
  int settings_used  = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  touch_pen_event_generator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("%0t ERROR %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic logic [COORD_BITS-1:0] scale_axis(input logic [COORD_BITS-1:0] raw,
                                                       input logic [CFG_W-1:0] size,
                                                       input logic [CFG_W-1:0] res);
    logic [2*COORD_BITS-1:0] prod;
    logic [2*COORD_BITS-1:0] quot;
    if (res == '0) begin
      return COORD_MAX;
    end
    prod = raw * size;
    quot = prod / res;
    return (quot > COORD_MAX) ? COORD_MAX : quot[COORD_BITS-1:0];
  endfunction

  function automatic bit axis_moved(input logic [COORD_BITS-1:0] a,
                                    input logic [COORD_BITS-1:0] b);
    int d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d > int'(cfg_drag_thr);
  endfunction

  // advances the pen state for one accepted poll, returns 1 when an event is due
  function automatic bit predict_pen_event(input in_item_t it, output out_item_t ev);
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    ev = '0;
    if (!it.touch_present) begin
      if (!pen_touched) begin
        return 1'b0;
      end
      pen_touched   = 1'b0;
      ev.event_kind = EV_UP;
      ev.pos_x      = last_px;
      ev.pos_y      = last_py;
      return 1'b1;
    end
    sx = scale_axis(it.raw_x, cfg_panel_w, cfg_res_x);
    sy = scale_axis(it.raw_y, cfg_panel_h, cfg_res_y);
    if (!pen_touched) begin
      pen_touched   = 1'b1;
      ev.event_kind = EV_DOWN;
    end else if (axis_moved(sx, last_px) || axis_moved(sy, last_py)) begin
      ev.event_kind = EV_DRAG;
    end else begin
      return 1'b0;
    end
    last_px  = sx;
    last_py  = sy;
    ev.pos_x = sx;
    ev.pos_y = sy;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(input int idx);
    case (idx)
      REG_PANEL_W:  return DATA_W'(cfg_panel_w);
      REG_PANEL_H:  return DATA_W'(cfg_panel_h);
      REG_RES_X:    return DATA_W'(cfg_res_x);
      REG_RES_Y:    return DATA_W'(cfg_res_y);
      REG_DRAG_THR: return DATA_W'(cfg_drag_thr);
      default:      return '0;
    endcase
  endfunction

  task automatic apb_write(input int idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << 2);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_PANEL_W:  cfg_panel_w  = value[CFG_W-1:0];
      REG_PANEL_H:  cfg_panel_h  = value[CFG_W-1:0];
      REG_RES_X:    cfg_res_x    = value[CFG_W-1:0];
      REG_RES_Y:    cfg_res_y    = value[CFG_W-1:0];
      REG_DRAG_THR: cfg_drag_thr = value[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input int idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx << 2);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== reg_value(idx)) begin
      report_error($sformatf("register %0d read %0h, want %0h", idx, prdata, reg_value(idx)));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_registers();
    for (int i = REG_PANEL_W; i <= REG_DRAG_THR; i++) begin
      apb_read_check(i);
    end
  endtask

  // upper data bits carry junk, the block keeps only the register width
  task automatic set_config(input int pw, input int ph, input int rx, input int ry,
                            input int thr);
    apb_write(REG_PANEL_W,  ($urandom & 32'hFFFF_F000) | pw);
    apb_write(REG_PANEL_H,  ($urandom & 32'hFFFF_F000) | ph);
    apb_write(REG_RES_X,    ($urandom & 32'hFFFF_F000) | rx);
    apb_write(REG_RES_Y,    ($urandom & 32'hFFFF_F000) | ry);
    apb_write(REG_DRAG_THR, ($urandom & 32'hFFFF_FF00) | thr);
    check_all_registers();
    settings_used++;
  endtask

  task automatic send_poll(input logic present, input int rx, input int ry);
    in_item_t  it;
    out_item_t ev;
    it.touch_present = present;
    it.raw_x         = COORD_BITS'(rx);
    it.raw_y         = COORD_BITS'(ry);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    polls_sent++;
    if (predict_pen_event(it, ev)) begin
      pending_events.push_back(ev);
    end
  endtask

  // drops valid and waits for every outstanding event; settle covers silent items
  task automatic wait_results(input bit settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  function automatic int drift(input int c);
    int mag;
    case ($urandom_range(3))
      0:       mag = $urandom_range(15);
      1:       mag = $urandom_range(80);
      2:       mag = $urandom_range(600);
      default: mag = 0;
    endcase
    c = $urandom_range(1) ? c + mag : c - mag;
    if (c < 0) c = 0;
    if (c > int'(COORD_MAX)) c = COORD_MAX;
    return c;
  endfunction

  function automatic int start_coord();
    case ($urandom_range(7))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(COORD_MAX);
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_events
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_events.size() == 0) begin
        report_error($sformatf("unexpected event kind %0d at (%0d,%0d)",
                               out_item.event_kind, out_item.pos_x, out_item.pos_y));
      end else begin
        want = pending_events.pop_front();
        if (out_item.event_kind !== want.event_kind) begin
          report_error($sformatf("event_kind %0d, want %0d",
                                 out_item.event_kind, want.event_kind));
        end
        if (out_item.pos_x !== want.pos_x) begin
          report_error($sformatf("pos_x %0d, want %0d (kind %0d)",
                                 out_item.pos_x, want.pos_x, want.event_kind));
        end
        if (out_item.pos_y !== want.pos_y) begin
          report_error($sformatf("pos_y %0d, want %0d (kind %0d)",
                                 out_item.pos_y, want.pos_y, want.event_kind));
        end
        case (want.event_kind)
          EV_DOWN: downs_seen++;
          EV_UP:   ups_seen++;
          default: drags_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_touch_pen_event_generator: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_register_defaults();
    check_all_registers();
    settings_used++;
  endtask

  // default scaling is one to one, so raw values land unchanged
  task automatic test_pen_sequence();
    send_poll(1'b0, 0, 0);
    send_poll(1'b0, COORD_MAX, COORD_MAX);
    send_poll(1'b1, 0, 0);
    send_poll(1'b1, 10, 10);
    send_poll(1'b1, 11, 0);
    send_poll(1'b1, 11, 11);
    send_poll(1'b1, COORD_MAX, COORD_MAX);
    send_poll(1'b1, COORD_MAX - 5, COORD_MAX);
    send_poll(1'b0, 0, 0);
    send_poll(1'b0, 0, 0);
    send_poll(1'b1, COORD_MAX, 0);
    send_poll(1'b1, 0, COORD_MAX);
    send_poll(1'b0, COORD_MAX, COORD_MAX);
    wait_results(1'b1);
  endtask

  task automatic test_scaling_edges();
    // full-scale output with zero threshold
    set_config(COORD_MAX, COORD_MAX, 1, 1, 0);
    send_poll(1'b1, 1, 0);
    send_poll(1'b1, 0, 1);
    send_poll(1'b1, 0, 1);
    send_poll(1'b1, 0, 0);
    send_poll(1'b0, 0, 0);
    wait_results(1'b1);
    // zero divisor on both axes
    set_config(800, 480, 0, 0, 255);
    send_poll(1'b1, 123, 456);
    send_poll(1'b1, 0, 0);
    send_poll(1'b0, 0, 0);
    wait_results(1'b1);
    // zero panel width, threshold at its top
    set_config(0, COORD_MAX, COORD_MAX, COORD_MAX, 255);
    send_poll(1'b1, COORD_MAX, 0);
    send_poll(1'b1, COORD_MAX, 255);
    send_poll(1'b1, COORD_MAX, 256);
    send_poll(1'b0, 0, 0);
    wait_results(1'b1);
    // addresses past the last register must not disturb anything
    for (int i = REG_DRAG_THR + 1; i < (1 << REG_IDX_W); i++) begin
      apb_write(i, $urandom);
    end
    check_all_registers();
  endtask

  task automatic test_backpressure();
    set_config(PANEL_W_RST, PANEL_H_RST, RES_X_RST, RES_Y_RST, DRAG_THR_RST);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = HOLD_CYCLES;
    send_poll(1'b1, 100, 100);
    for (int i = 1; i <= 15; i++) begin
      send_poll(1'b1, 100 + 50 * i, 100 + 20 * i);
    end
    send_poll(1'b0, 0, 0);
    // sender waits here for the backlog to drain
    wait_results(1'b0);
    for (int i = 0; i < 5; i++) begin
      send_poll(1'b1, 3000 - 200 * i, 2000);
    end
    send_poll(1'b0, 0, 0);
    wait_results(1'b1);
  endtask

  task automatic run_random(input int n_polls);
    int first;
    int len;
    int x;
    int y;
    first = polls_sent;
    while (polls_sent - first < n_polls) begin
      if ($urandom_range(99) < 80) begin
        // a stroke: down, a run of moves, then release
        x   = start_coord();
        y   = start_coord();
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_poll(1'b1, x, y);
          x = drift(x);
          y = drift(y);
        end
        repeat ($urandom_range(1, 2)) send_poll(1'b0, $urandom_range(COORD_MAX),
                                                $urandom_range(COORD_MAX));
      end else begin
        send_poll(1'($urandom_range(1)), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX));
      end
      if ($urandom_range(49) == 0) begin
        wait_results(1'b0);
      end
    end
  endtask

  task automatic test_random_settings();
    int pw;
    int ph;
    int rx;
    int ry;
    int thr;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_results(1'b1);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 78; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      pw  = $urandom_range(1, COORD_MAX);
      ph  = $urandom_range(1, COORD_MAX);
      rx  = $urandom_range(3) == 0 ? 0 : $urandom_range(1, COORD_MAX);
      ry  = $urandom_range(1, COORD_MAX);
      thr = $urandom_range(255);
      case (p)
        0: set_config(PANEL_W_RST, PANEL_H_RST, RES_X_RST, RES_Y_RST, DRAG_THR_RST);
        1: set_config(COORD_MAX, COORD_MAX, 1, 1, 0);
        2: set_config(1, 1, COORD_MAX, COORD_MAX, 255);
        3: set_config(1920, 1080, COORD_MAX, COORD_MAX, 255);
        4: set_config(800, 480, 0, COORD_MAX, 3);
        5: set_config(pw, ph, rx, ry, thr);
        6: set_config(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        default: set_config(pw, ph, ry, rx, $urandom_range(20));
      endcase
      run_random(PHASE_POLLS);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_register_defaults();
    test_pen_sequence();
    test_scaling_edges();
    test_backpressure();
    test_random_settings();
    wait_results(1'b1);
    $display("run covered %0d polls and %0d events (%0d down, %0d up, %0d drag)",
             polls_sent, downs_seen + ups_seen + drags_seen, downs_seen, ups_seen, drags_seen);
    $display("over %0d register settings, saturation, zero divisors and four idling mixes",
             settings_used);
    if (error_count == 0) begin
      $display("tb_touch_pen_event_generator: done, clean");
    end else begin
      $display("tb_touch_pen_event_generator: done, errors");
    end
    $finish;
  end

endmodule
